[hdl/biou_pkg.sv]
// shared widths, payload types and span helpers for the box overlap core
`timescale 1ns / 1ps

package biou_pkg;

   // coordinate and ratio precision
   localparam int COORD_BITS = 16;
   localparam int RATIO_BITS = 16;

   // derived widths
   localparam int SPAN_W     = COORD_BITS;
   localparam int AREA_W     = 2 * COORD_BITS;
   localparam int UNI_W      = 2 * COORD_BITS + 1;
   localparam int QUO_W      = RATIO_BITS + 1;
   localparam int DIV_STAGES = RATIO_BITS + 1;

   // one box pair
   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_left;
      logic signed [COORD_BITS-1:0] a_top;
      logic signed [COORD_BITS-1:0] a_right;
      logic signed [COORD_BITS-1:0] a_bottom;
      logic signed [COORD_BITS-1:0] b_left;
      logic signed [COORD_BITS-1:0] b_top;
      logic signed [COORD_BITS-1:0] b_right;
      logic signed [COORD_BITS-1:0] b_bottom;
   } req_word_type;

   // one overlap result
   typedef struct packed {
      logic [QUO_W-1:0] overlap_ratio;
      logic             empty_union;
   } rsp_word_type;

   // operands handed to the divider
   typedef struct packed {
      logic [UNI_W-1:0] num;
      logic [UNI_W-1:0] den;
      logic             empty;
   } div_word_type;

   // one divider step's partial result
   typedef struct packed {
      logic [UNI_W-1:0] rem;
      logic [UNI_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             empty;
   } div_stage_type;

   // hi - lo at full precision, negative clamped to zero
   function automatic logic [SPAN_W-1:0] clamp_span(
      input logic signed [COORD_BITS-1:0] lo,
      input logic signed [COORD_BITS-1:0] hi
   );
      logic signed [COORD_BITS:0] diff;
      diff = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
      return (diff > 0) ? diff[SPAN_W-1:0] : '0;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] smax(
      input logic signed [COORD_BITS-1:0] x,
      input logic signed [COORD_BITS-1:0] y
   );
      return (x > y) ? x : y;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] smin(
      input logic signed [COORD_BITS-1:0] x,
      input logic signed [COORD_BITS-1:0] y
   );
      return (x < y) ? x : y;
   endfunction

endpackage

[hdl/biou_divider.sv]
// pipelined restoring divider: one quotient bit per stage, intersection over union
`timescale 1ns / 1ps

module biou_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  biou_pkg::div_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_stall,
   output biou_pkg::rsp_word_type out_word
);

   localparam int N = biou_pkg::DIV_STAGES;
   localparam int UW = biou_pkg::UNI_W;
   localparam int QW = biou_pkg::QUO_W;

   biou_pkg::div_stage_type st_ff [N];
   biou_pkg::div_stage_type st_in [N];
   logic [N-1:0]            v_ff;
   logic [N:0]              en;

   // a stage loads when empty or when the one after it moves
   assign en[N] = !out_stall;
   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_en
         assign en[k] = !v_ff[k] || en[k+1];
      end
   endgenerate

   assign in_stall = !en[0];

   // integer bit: ratio reaches one only for equal operands
   always_comb begin
      st_in[0].den   = in_word.den;
      st_in[0].empty = in_word.empty;
      if (in_word.num >= in_word.den) begin
         st_in[0].rem = in_word.num - in_word.den;
         st_in[0].quo = QW'(1);
      end else begin
         st_in[0].rem = in_word.num;
         st_in[0].quo = '0;
      end
   end

   // fraction bits, one shift and compare-subtract per stage
   generate
      for (k = 1; k < N; k++) begin : g_step
         logic [UW:0] trial;
         logic        ge;
         always_comb begin
            trial           = {st_ff[k-1].rem, 1'b0};
            ge              = trial >= {1'b0, st_ff[k-1].den};
            st_in[k].den    = st_ff[k-1].den;
            st_in[k].empty  = st_ff[k-1].empty;
            st_in[k].rem    = ge ? UW'(trial - {1'b0, st_ff[k-1].den}) : UW'(trial);
            st_in[k].quo    = {st_ff[k-1].quo[QW-2:0], ge};
         end
      end
   endgenerate

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < N; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // stage payloads
   generate
      for (k = 0; k < N; k++) begin : g_reg
         always_ff @(posedge clock) begin
            if (en[k]) begin
               st_ff[k] <= st_in[k];
            end
         end
      end
   endgenerate

   // empty union forces the ratio to zero
   assign out_valid              = v_ff[N-1];
   assign out_word.empty_union   = st_ff[N-1].empty;
   assign out_word.overlap_ratio = st_ff[N-1].empty ? '0 : st_ff[N-1].quo;

endmodule

[hdl/box_intersection_over_union_core.sv]
// top level: box pair intersection over union, fully pipelined
//
//   channel   direction   ports                              word type
//   req       in          req_valid req_stall req_word       req_word_type
//   rsp       out         rsp_valid rsp_stall rsp_word       rsp_word_type
//
// one box pair enters per cycle while req_stall is low; a result passes through the span,
// multiply and union stages, then through one divider stage per quotient bit.
// reset clears only the valid bits; no payload register is reset.
// rsp_stall freezes only occupied stages, so bubbles close up and req keeps
// flowing until the whole pipe is full.
`timescale 1ns / 1ps

module box_intersection_over_union_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  biou_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output biou_pkg::rsp_word_type rsp_word
);

   localparam int CB = biou_pkg::COORD_BITS;
   localparam int SW = biou_pkg::SPAN_W;
   localparam int AW = biou_pkg::AREA_W;
   localparam int UW = biou_pkg::UNI_W;

   // stage 1: box spans and overlap bounds
   logic                 s1_v_ff;
   logic [SW-1:0]        aw_ff, ah_ff, bw_ff, bh_ff;
   logic signed [CB-1:0] ix_lo_ff, ix_hi_ff, iy_lo_ff, iy_hi_ff;

   // stage 2: box areas and overlap spans
   logic                 s2_v_ff;
   logic [AW-1:0]        s2_area_a_ff, s2_area_b_ff;
   logic [SW-1:0]        iw_ff, ih_ff;

   // stage 3: intersection area
   logic                 s3_v_ff;
   logic [AW-1:0]        s3_area_a_ff, s3_area_b_ff, inter_ff;

   // stage 4: union and divider operands
   logic                   s4_v_ff;
   biou_pkg::div_word_type div_ff;
   biou_pkg::div_word_type div_in;
   logic [UW-1:0]          uni_in;

   logic s1_en, s2_en, s3_en, s4_en;
   logic div_stall;

   // stall ripples back only through occupied stages
   assign s4_en     = !s4_v_ff || !div_stall;
   assign s3_en     = !s3_v_ff || s4_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_stall = !s1_en;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_en) s1_v_ff <= req_valid;
         if (s2_en) s2_v_ff <= s1_v_ff;
         if (s3_en) s3_v_ff <= s2_v_ff;
         if (s4_en) s4_v_ff <= s3_v_ff;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (s1_en) begin
         aw_ff    <= biou_pkg::clamp_span(req_word.a_left, req_word.a_right);
         ah_ff    <= biou_pkg::clamp_span(req_word.a_top, req_word.a_bottom);
         bw_ff    <= biou_pkg::clamp_span(req_word.b_left, req_word.b_right);
         bh_ff    <= biou_pkg::clamp_span(req_word.b_top, req_word.b_bottom);
         ix_lo_ff <= biou_pkg::smax(req_word.a_left, req_word.b_left);
         ix_hi_ff <= biou_pkg::smin(req_word.a_right, req_word.b_right);
         iy_lo_ff <= biou_pkg::smax(req_word.a_top, req_word.b_top);
         iy_hi_ff <= biou_pkg::smin(req_word.a_bottom, req_word.b_bottom);
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_area_a_ff <= AW'(aw_ff) * AW'(ah_ff);
         s2_area_b_ff <= AW'(bw_ff) * AW'(bh_ff);
         iw_ff        <= biou_pkg::clamp_span(ix_lo_ff, ix_hi_ff);
         ih_ff        <= biou_pkg::clamp_span(iy_lo_ff, iy_hi_ff);
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_area_a_ff <= s2_area_a_ff;
         s3_area_b_ff <= s2_area_b_ff;
         inter_ff     <= AW'(iw_ff) * AW'(ih_ff);
      end
   end

   // stage 4: union never goes negative, zero marks an empty pair
   always_comb begin
      uni_in       = UW'(s3_area_a_ff) + UW'(s3_area_b_ff) - UW'(inter_ff);
      div_in.num   = UW'(inter_ff);
      div_in.den   = uni_in;
      div_in.empty = (uni_in == '0);
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         div_ff <= div_in;
      end
   end

   // ratio divider
   biou_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_v_ff),
      .in_stall  (div_stall),
      .in_word   (div_ff),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

[tb/sv/tb_top.sv]
// testbench for the box pair intersection over union core: directed rows, then random pairs
`timescale 1ns / 1ps

module tb_top;

   localparam int STUCK_LIMIT = 5000;
   localparam int TAIL_CYCLES = 30;
   localparam int RANDOM_PAIRS = 950;
   localparam int REPORT_MAX = 10;
   localparam int CB = biou_pkg::COORD_BITS;
   localparam int RB = biou_pkg::RATIO_BITS;
   localparam int QW = biou_pkg::QUO_W;

   // one row of the directed table
   typedef struct {
      biou_pkg::req_word_type pair;
      bit                     typed;
      biou_pkg::rsp_word_type ratio;
   } pair_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   biou_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   biou_pkg::rsp_word_type rsp_word;

   biou_pkg::rsp_word_type pending_ratios[$];
   pair_row_type           directed_rows[$];
   biou_pkg::rsp_word_type want;
   int                     error_count = 0;
   int                     words_seen = 0;
   int                     stuck_cycles = 0;

   box_intersection_over_union_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // signed span with negative widths clamped to zero
   function automatic longint span_len(input longint lo, input longint hi);
      return (hi > lo) ? hi - lo : 0;
   endfunction

   // expected overlap word for one box pair
   function automatic biou_pkg::rsp_word_type overlap_of(input biou_pkg::req_word_type p);
      longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      longint area_a, area_b, inter, uni;
      biou_pkg::rsp_word_type r;
      ax1 = longint'(p.a_left);
      ay1 = longint'(p.a_top);
      ax2 = longint'(p.a_right);
      ay2 = longint'(p.a_bottom);
      bx1 = longint'(p.b_left);
      by1 = longint'(p.b_top);
      bx2 = longint'(p.b_right);
      by2 = longint'(p.b_bottom);
      area_a = span_len(ax1, ax2) * span_len(ay1, ay2);
      area_b = span_len(bx1, bx2) * span_len(by1, by2);
      inter = span_len((ax1 > bx1) ? ax1 : bx1, (ax2 < bx2) ? ax2 : bx2)
            * span_len((ay1 > by1) ? ay1 : by1, (ay2 < by2) ? ay2 : by2);
      uni = area_a + area_b - inter;
      if (uni <= 0) begin
         r.overlap_ratio = '0;
         r.empty_union = 1'b1;
      end else begin
         r.overlap_ratio = QW'((inter << RB) / uni);
         r.empty_union = 1'b0;
      end
      return r;
   endfunction

   // build one directed row
   function automatic pair_row_type mk(input int al, input int at, input int ar, input int ab,
                                       input int bl, input int bt, input int br, input int bb,
                                       input bit typed, input int ratio, input bit empty);
      pair_row_type row;
      row.pair.a_left = CB'(al);
      row.pair.a_top = CB'(at);
      row.pair.a_right = CB'(ar);
      row.pair.a_bottom = CB'(ab);
      row.pair.b_left = CB'(bl);
      row.pair.b_top = CB'(bt);
      row.pair.b_right = CB'(br);
      row.pair.b_bottom = CB'(bb);
      row.typed = typed;
      row.ratio.overlap_ratio = QW'(ratio);
      row.ratio.empty_union = empty;
      return row;
   endfunction

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic logic signed [CB-1:0] fit(input int v);
      if (v < -32768) return CB'(-32768);
      if (v > 32767) return CB'(32767);
      return CB'(v);
   endfunction

   // random pair: mostly nearby well-formed boxes, plus raw, inverted and degenerate ones
   function automatic biou_pkg::req_word_type random_pair();
      int kind, sz, d, w, h, t;
      int al, at, ar, ab, bl, bt, br, bb;
      biou_pkg::req_word_type p;
      kind = pick(0, 19);
      sz = (pick(0, 19) == 0) ? 30000 : 400;
      d = sz / 2;
      w = pick(1, sz);
      h = pick(1, sz);
      al = pick(-32768, 32767 - w);
      at = pick(-32768, 32767 - h);
      ar = al + w;
      ab = at + h;
      bl = al + pick(-d, d);
      bt = at + pick(-d, d);
      br = ar + pick(-d, d);
      bb = ab + pick(-d, d);
      case (kind)
         12, 13: begin
            bl = al; bt = at; br = ar; bb = ab;
         end
         16: begin
            if (pick(0, 1) == 1) begin t = al; al = ar; ar = t; end
            else begin t = at; at = ab; ab = t; end
         end
         17: begin
            t = bl; bl = br; br = t;
            if (pick(0, 1) == 1) begin t = al; al = ar; ar = t; end
         end
         18: begin
            ar = al;
            if (pick(0, 1) == 1) bb = bt;
         end
         19: begin
            bl = al - pick(0, d); bt = at - pick(0, d);
            br = ar + pick(0, d); bb = ab + pick(0, d);
         end
         default: ;
      endcase
      p.a_left = fit(al);
      p.a_top = fit(at);
      p.a_right = fit(ar);
      p.a_bottom = fit(ab);
      p.b_left = fit(bl);
      p.b_top = fit(bt);
      p.b_right = fit(br);
      p.b_bottom = fit(bb);
      if (kind == 14 || kind == 15) p = {$urandom, $urandom, $urandom, $urandom};
      return p;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%s", msg);
   endtask

   // present one pair at the falling edge, hold until taken, then idle for the given gap
   task automatic send_pair(input biou_pkg::req_word_type p,
                            input biou_pkg::rsp_word_type expected, input int gap);
      req_word <= p;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_ratios.push_back(expected);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_word <= {$urandom, $urandom, $urandom, $urandom};
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_ratios();
      while (pending_ratios.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver stall pattern with a stall rate that is rerolled, sometimes with no stall at all
   initial begin
      int pct, n;
      rsp_stall = 1'b0;
      pct = 0;
      n = 0;
      forever begin
         @(negedge clock);
         if (n == 0) begin
            case (pick(0, 4))
               0, 1: pct = 0;
               2: pct = 20;
               3: pct = 50;
               default: pct = 85;
            endcase
            n = 150;
         end
         n--;
         rsp_stall <= (pick(0, 99) < pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ratios.size() == 0) begin
            report_error($sformatf("word with nothing pending: ratio %0d empty %0d",
                                   rsp_word.overlap_ratio, rsp_word.empty_union));
         end else begin
            want = pending_ratios.pop_front();
            if (rsp_word.overlap_ratio !== want.overlap_ratio ||
                rsp_word.empty_union !== want.empty_union)
               report_error($sformatf(
                  "mismatch at word %0d: ratio exp %0d got %0d, empty exp %0d got %0d",
                  words_seen, want.overlap_ratio, rsp_word.overlap_ratio,
                  want.empty_union, rsp_word.empty_union));
         end
         words_seen++;
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // stimulus
   initial begin
      int i, gap, burst_left;
      bit calm;
      pair_row_type row_now;
      biou_pkg::req_word_type p;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      burst_left = 0;

      // identical, empty union, inverted, disjoint, touching, extremes
      directed_rows.push_back(mk(0, 0, 160, 160, 0, 0, 160, 160, 1, 65536, 0));
      directed_rows.push_back(mk(-32768, -32768, 32767, 32767,
                                 -32768, -32768, 32767, 32767, 1, 65536, 0));
      directed_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      directed_rows.push_back(mk(160, 160, 0, 0, 50, 50, -50, -50, 1, 0, 1));
      directed_rows.push_back(mk(-32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768, -32768, 1, 0, 1));
      directed_rows.push_back(mk(32767, 32767, 32767, 32767,
                                 32767, 32767, 32767, 32767, 1, 0, 1));
      directed_rows.push_back(mk(0, 0, 160, 160, 320, 320, 480, 480, 1, 0, 0));
      directed_rows.push_back(mk(0, 0, 160, 160, 160, 0, 320, 160, 1, 0, 0));
      directed_rows.push_back(mk(0, 0, 160, 160, 160, 160, 0, 0, 1, 0, 0));
      directed_rows.push_back(mk(160, 0, 0, 160, 0, 0, 160, 160, 1, 0, 0));
      directed_rows.push_back(mk(-32768, -32768, 32767, 32767, 0, 0, 0, 16, 1, 0, 0));
      directed_rows.push_back(mk(-1, -1, 0, 0, -1, -1, 0, 0, 1, 65536, 0));
      // partial overlaps and nesting, left to the predictor
      directed_rows.push_back(mk(0, 0, 160, 160, 80, 0, 240, 160, 0, 0, 0));
      directed_rows.push_back(mk(0, 0, 160, 160, -160, -160, 320, 320, 0, 0, 0));
      directed_rows.push_back(mk(-32768, -32768, 32767, 32767, 0, 0, 16, 16, 0, 0, 0));
      directed_rows.push_back(mk(-32768, 0, 32767, 16, 32766, 0, 32767, 16, 0, 0, 0));
      directed_rows.push_back(mk(32000, 32000, 32767, 32767,
                                 -32768, -32768, 32767, 32767, 0, 0, 0));
      directed_rows.push_back(mk(0, 0, 1, 1, 0, 0, 1, 2, 0, 0, 0));
      directed_rows.push_back(mk(0, 0, 3, 1, 0, 0, 1, 1, 0, 0, 0));
      directed_rows.push_back(mk(-32768, 32767, 32767, -32768,
                                 32767, -32768, -32768, 32767, 0, 0, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, back to back except for a short gap every few rows
      for (i = 0; i < directed_rows.size(); i++) begin
         row_now = directed_rows[i];
         gap = (i == directed_rows.size() - 1 || i % 5 == 4) ? pick(1, 3) : 0;
         send_pair(row_now.pair,
                   row_now.typed ? row_now.ratio : overlap_of(row_now.pair), gap);
      end
      drain_ratios();

      // random pairs in bursts, with one stretch of full rate and one full drain
      for (i = 0; i < RANDOM_PAIRS; i++) begin
         calm = (i >= 200 && i < 350);
         if (burst_left == 0) begin
            burst_left = pick(1, 24);
            gap = calm ? 0 : pick(1, 6);
         end else begin
            gap = 0;
         end
         burst_left--;
         if (i == RANDOM_PAIRS - 1 || i == 500) gap = (gap == 0) ? 1 : gap;
         p = random_pair();
         send_pair(p, overlap_of(p), gap);
         if (i == 500) drain_ratios();
      end

      while (pending_ratios.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_ratios.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
